### design/qas_pkg.sv
`timescale 1ns / 1ps
package qas_pkg;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned DEPTH_W     = 8;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'hFF;

  typedef struct packed {
    logic take;
    logic bound;
    logic check;
    logic fetch;
    logic push_char;
    logic push_mark;
    logic finish;
    logic is_end;
  } qas_cmd_t;

  typedef struct packed {
    logic comma_split;
    logic empty;
    logic last_char;
    logic out_free;
  } qas_status_t;

endpackage

### design/qas_ram.sv
`timescale 1ns / 1ps
module qas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/qas_datapath.sv
`timescale 1ns / 1ps
module qas_datapath
  import qas_pkg::*;
#(
  parameter int unsigned MAX_PARAM_LEN = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  qas_cmd_t               cmd_i,
  output qas_status_t            status_o,
  input  logic [IN_TDATA_W-1:0]  in_char_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_tdata_o,
  output logic                   out_tuser_o,
  output logic                   out_tlast_o
);

  localparam int unsigned AW = $clog2(MAX_PARAM_LEN);
  localparam int unsigned LW = $clog2(MAX_PARAM_LEN + 1);

  logic [LW-1:0]      len_q, len_d;
  logic [LW-1:0]      tss_q, tss_d;
  logic               inq_q, inq_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               pbs_q, pbs_d;
  logic               pesc_q, pesc_d;
  logic               any_q, any_d;
  logic               ovf_q, ovf_d;
  logic               fq_q, fq_d;
  logic [LW-1:0]      idx_q, idx_d;
  logic [LW-1:0]      end_q, end_d;
  logic               out_valid_q, out_valid_d;

  logic [7:0]         out_char_q;
  logic               out_pres_q, out_pe_q, out_se_q, out_un_q, out_ov_q;

  logic               escaped, inq_upd, do_append, comma_split;
  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [7:0]         rdata;
  logic [LW-1:0]      eff_len, first_v, end_v, idx_inc;
  logic               strip, unterm, last_char, out_free, mark_pe;

  qas_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PARAM_LEN)
  ) u_qas_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_char_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign comma_split = (in_char_i == CH_COMMA) && !inq_q && (depth_q == '0);
  assign escaped     = pbs_q && !pesc_q;
  assign eff_len     = ((tss_q != '0) && (tss_q < len_q)) ? tss_q : len_q;
  assign strip       = (eff_len > LW'(1)) && fq_q && (rdata == CH_QUOTE);
  assign first_v     = LW'(strip);
  assign end_v       = strip ? (eff_len - LW'(1)) : eff_len;
  assign idx_inc     = idx_q + LW'(1);
  assign last_char   = (idx_inc == end_q);
  assign unterm      = inq_q || (depth_q != '0);
  assign out_free    = !out_valid_q || out_ready_i;
  assign mark_pe     = !(cmd_i.is_end && !any_q);

  assign re    = cmd_i.bound || cmd_i.fetch;
  assign raddr = cmd_i.bound ? AW'(eff_len - LW'(1)) : AW'(idx_q);

  always_comb begin
    len_d       = len_q;
    tss_d       = tss_q;
    inq_d       = inq_q;
    depth_d     = depth_q;
    pbs_d       = pbs_q;
    pesc_d      = pesc_q;
    any_d       = any_q;
    ovf_d       = ovf_q;
    fq_d        = fq_q;
    idx_d       = idx_q;
    end_d       = end_q;
    inq_upd     = inq_q;
    do_append   = 1'b0;
    we          = 1'b0;
    waddr       = AW'(len_q);
    if (cmd_i.take) begin
      pesc_d = escaped;
      pbs_d  = (in_char_i == CH_BSLASH);
      if (inq_q) begin
        if ((in_char_i == CH_QUOTE) && !escaped) inq_upd = 1'b0;
      end else begin
        if ((in_char_i == CH_QUOTE) && !escaped) inq_upd = 1'b1;
        if ((depth_q != '0) && (in_char_i == CH_CLOSE)) depth_d = depth_q - 8'd1;
        if ((in_char_i == CH_OPEN) && (depth_q != DEPTH_MAX)) depth_d = depth_q + 8'd1;
      end
      inq_d = inq_upd;
      if (!comma_split) begin
        if (((in_char_i == CH_QUOTE) || (in_char_i == CH_BSLASH)) && escaped) begin
          if (!ovf_q && (len_q != '0)) begin
            we    = 1'b1;
            waddr = AW'(len_q - LW'(1));
            if (len_q == LW'(1)) fq_d = (in_char_i == CH_QUOTE);
          end
        end else if ((in_char_i == CH_SPACE) && !inq_upd) begin
          if (len_q != '0) begin
            if (tss_q == '0) tss_d = len_q;
            do_append = 1'b1;
          end
        end else begin
          tss_d     = '0;
          do_append = 1'b1;
        end
        if (do_append) begin
          if (len_q < LW'(MAX_PARAM_LEN)) begin
            we    = 1'b1;
            waddr = AW'(len_q);
            len_d = len_q + LW'(1);
            if (len_q == '0) fq_d = (in_char_i == CH_QUOTE);
          end else begin
            ovf_d = 1'b1;
          end
        end
      end
    end
    if (cmd_i.check) begin
      idx_d = first_v;
      end_d = end_v;
    end
    if (cmd_i.push_char) begin
      idx_d = idx_inc;
    end
    if (cmd_i.finish) begin
      len_d = '0;
      tss_d = '0;
      ovf_d = 1'b0;
      any_d = 1'b1;
      if (cmd_i.is_end) begin
        any_d   = 1'b0;
        inq_d   = 1'b0;
        depth_d = '0;
        pbs_d   = 1'b0;
        pesc_d  = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.push_char || cmd_i.push_mark) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      tss_q       <= '0;
      inq_q       <= 1'b0;
      depth_q     <= '0;
      pbs_q       <= 1'b0;
      pesc_q      <= 1'b0;
      any_q       <= 1'b0;
      ovf_q       <= 1'b0;
      fq_q        <= 1'b0;
      idx_q       <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      tss_q       <= tss_d;
      inq_q       <= inq_d;
      depth_q     <= depth_d;
      pbs_q       <= pbs_d;
      pesc_q      <= pesc_d;
      any_q       <= any_d;
      ovf_q       <= ovf_d;
      fq_q        <= fq_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_char) begin
      out_char_q <= rdata;
      out_pres_q <= 1'b1;
      out_pe_q   <= last_char;
      out_se_q   <= last_char && cmd_i.is_end;
      out_un_q   <= last_char && cmd_i.is_end && unterm;
      out_ov_q   <= last_char && ovf_q;
    end else if (cmd_i.push_mark) begin
      out_char_q <= 8'h00;
      out_pres_q <= 1'b0;
      out_pe_q   <= mark_pe;
      out_se_q   <= cmd_i.is_end;
      out_un_q   <= cmd_i.is_end && unterm;
      out_ov_q   <= mark_pe && ovf_q;
    end
  end

  assign status_o.comma_split = comma_split;
  assign status_o.empty       = (end_v <= first_v);
  assign status_o.last_char   = last_char;
  assign status_o.out_free    = out_free;

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = {5'b00000, out_ov_q, out_un_q, out_se_q, out_char_q};
  assign out_tuser_o = out_pres_q;
  assign out_tlast_o = out_pe_q;

endmodule

### design/qas_controller.sv
`timescale 1ns / 1ps
module qas_controller
  import qas_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_present_i,
  input  logic        in_last_i,
  input  qas_status_t status_i,
  output qas_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_BOUND = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_FETCH = 6'b001000,
    ST_PUSH  = 6'b010000,
    ST_MARK  = 6'b100000
  } qas_state_e;

  qas_state_e state_q, state_d;
  logic       is_end_q, is_end_d;
  logic       pend_q, pend_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    is_end_d        = is_end_q;
    pend_d          = pend_q;
    cmd_o           = '0;
    cmd_o.is_end    = is_end_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.take = in_present_i;
          if (in_present_i && status_i.comma_split) begin
            state_d  = ST_BOUND;
            is_end_d = 1'b0;
            pend_d   = in_last_i;
          end else if (in_last_i) begin
            state_d  = ST_BOUND;
            is_end_d = 1'b1;
            pend_d   = 1'b0;
          end
        end
      end
      ST_BOUND: begin
        cmd_o.bound = 1'b1;
        state_d     = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.empty ? ST_MARK : ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_PUSH;
      end
      ST_PUSH: begin
        if (status_i.out_free) begin
          cmd_o.push_char = 1'b1;
          if (status_i.last_char) begin
            cmd_o.finish = 1'b1;
            state_d      = pend_q ? ST_BOUND : ST_IDLE;
            is_end_d     = pend_q;
            pend_d       = 1'b0;
          end else begin
            state_d = ST_FETCH;
          end
        end
      end
      ST_MARK: begin
        if (status_i.out_free) begin
          cmd_o.push_mark = 1'b1;
          cmd_o.finish    = 1'b1;
          state_d         = pend_q ? ST_BOUND : ST_IDLE;
          is_end_d        = pend_q;
          pend_d          = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      is_end_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      is_end_q <= is_end_d;
      pend_q   <= pend_d;
    end
  end

endmodule

### design/quoted_argument_splitter.sv
`timescale 1ns / 1ps
// An ordinary character beat is taken in the idle state; the input stays ready.
// A split comma or a tlast beat holds the input through bound lookup (BOUND, CHECK), then
// FETCH and PUSH per character or MARK for an empty marker, longer while the output stalls.
// First result beat is registered by PUSH after BOUND, CHECK, FETCH, or by MARK if empty.
// Reset (rst_ni, asynchronous, active low) clears all control state; the character
// RAM is not cleared and needs no clearing pass.
module quoted_argument_splitter
  import qas_pkg::*;
#(
  parameter int unsigned MAX_PARAM_LEN = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [7:0] in_char
  input  logic                   s_axis_tuser_i,  // [0] in_char_present
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [7:0] out_char, [8] string_end, [9] unterminated, [10] overflowed
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tuser_o,  // [0] out_char_present
  output logic                   m_axis_tlast_o   // param_end
);

  qas_cmd_t    cmd;
  qas_status_t status;

  qas_controller u_qas_controller (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_present_i (s_axis_tuser_i),
    .in_last_i    (s_axis_tlast_i),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  qas_datapath #(
    .MAX_PARAM_LEN (MAX_PARAM_LEN)
  ) u_qas_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_char_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tdata_o (m_axis_tdata_o),
    .out_tuser_o (m_axis_tuser_o),
    .out_tlast_o (m_axis_tlast_o)
  );

endmodule

### design/qas_checker.sv
`timescale 1ns / 1ps
module qas_checker
  import qas_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic                   s_axis_tlast_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic                   m_axis_tuser_o,
  input logic                   m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken during final emission");

  a_char_end_is_param_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o && m_axis_tdata_o[8] |-> m_axis_tlast_o)
    else $error("string end on a character without parameter end");

  a_unterm_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[9] |-> m_axis_tdata_o[8])
    else $error("unterminated flag away from string end");

  a_ovf_at_param_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[10] |-> m_axis_tlast_o)
    else $error("overflow flag away from parameter end");

endmodule

bind quoted_argument_splitter qas_checker u_qas_checker (.*);

### test/tb_quoted_argument_splitter.sv
`timescale 1ns / 1ps
module tb_quoted_argument_splitter;
  import qas_pkg::*;

  localparam int unsigned PARAM_LEN      = 32;
  localparam int unsigned LEN_W          = $clog2(PARAM_LEN + 1);
  localparam int unsigned IDX_W          = $clog2(PARAM_LEN);
  localparam int unsigned RESET_CYCLES   = 4;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS    = 40;
  localparam logic [7:0]  LOWER_A        = 8'h61;

  typedef logic [7:0] text_t[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       present;
    logic       param_end;
    logic       string_end;
    logic       unterm;
    logic       overflow;
  } arg_beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tuser_i = 1'b0;
  logic                   s_axis_tlast_i = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  // predicted splitter state
  logic [7:0]         arg_store [PARAM_LEN];
  logic [LEN_W-1:0]   arg_len = '0;
  logic [LEN_W-1:0]   trail_from = '0;
  logic               in_quotes = 1'b0;
  logic [DEPTH_W-1:0] nest_depth = '0;
  logic               last_was_bslash = 1'b0;
  logic               last_was_escaped = 1'b0;
  logic               param_done = 1'b0;
  logic               dropped_chars = 1'b0;

  arg_beat_t param_beats_due[$];
  arg_beat_t head_beat;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_req = 0;
  int hold_left = 0;
  bit noise_on = 1'b0;
  int items_sent = 0;
  int strings_sent = 0;
  int beats_checked = 0;
  int params_checked = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  quoted_argument_splitter #(
    .MAX_PARAM_LEN(PARAM_LEN)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_split();
    arg_len = '0;
    trail_from = '0;
    in_quotes = 1'b0;
    nest_depth = '0;
    last_was_bslash = 1'b0;
    last_was_escaped = 1'b0;
    param_done = 1'b0;
    dropped_chars = 1'b0;
  endfunction

  function automatic logic [7:0] rand_lower();
    return LOWER_A + 8'($urandom_range(25));
  endfunction

  function automatic void trimmed_span(output logic [LEN_W-1:0] lo,
                                       output logic [LEN_W-1:0] hi);
    logic [LEN_W-1:0] n;
    n = arg_len;
    if (trail_from != 0 && trail_from < n) n = trail_from;
    lo = '0;
    hi = n;
    if (n > 1 && arg_store[0] == CH_QUOTE && arg_store[IDX_W'(n - 1)] == CH_QUOTE) begin
      lo = LEN_W'(1);
      hi = n - LEN_W'(1);
    end
  endfunction

  function automatic void queue_param(logic is_end, logic unterm);
    logic [LEN_W-1:0] lo, hi;
    arg_beat_t b;
    int i;
    trimmed_span(lo, hi);
    if (hi <= lo) begin
      b = '{ch: 8'h00, present: 1'b0, param_end: 1'b1, string_end: is_end,
            unterm: is_end && unterm, overflow: dropped_chars};
      param_beats_due = {param_beats_due, b};
    end else begin
      for (i = int'(lo); i < int'(hi); i++) begin
        b.ch         = arg_store[IDX_W'(i)];
        b.present    = 1'b1;
        b.param_end  = (i + 1 == int'(hi));
        b.string_end = b.param_end && is_end;
        b.unterm     = b.param_end && is_end && unterm;
        b.overflow   = b.param_end && dropped_chars;
        param_beats_due = {param_beats_due, b};
      end
    end
    arg_len = '0;
    trail_from = '0;
    dropped_chars = 1'b0;
    param_done = 1'b1;
  endfunction

  function automatic void absorb_char(logic [7:0] ch);
    logic escaped;
    escaped = last_was_bslash && !last_was_escaped;
    last_was_escaped = escaped;
    last_was_bslash = (ch == CH_BSLASH);
    if (in_quotes) begin
      if (ch == CH_QUOTE && !escaped) in_quotes = 1'b0;
    end else begin
      if (ch == CH_QUOTE && !escaped) in_quotes = 1'b1;
      if (nest_depth != 0 && ch == CH_CLOSE) nest_depth = nest_depth - 1'b1;
      if (ch == CH_OPEN && nest_depth != DEPTH_MAX) nest_depth = nest_depth + 1'b1;
      if (nest_depth == 0 && ch == CH_COMMA) begin
        queue_param(1'b0, 1'b0);
        return;
      end
    end
    // escaped quote or backslash overwrites its backslash
    if ((ch == CH_QUOTE || ch == CH_BSLASH) && escaped) begin
      if (!dropped_chars && arg_len != 0) arg_store[IDX_W'(arg_len - 1'b1)] = ch;
      return;
    end
    if (ch == CH_SPACE && !in_quotes) begin
      if (arg_len == 0) return;
      if (trail_from == 0) trail_from = arg_len;
    end else begin
      trail_from = '0;
    end
    if (arg_len < PARAM_LEN) begin
      arg_store[IDX_W'(arg_len)] = ch;
      arg_len = arg_len + 1'b1;
    end else begin
      dropped_chars = 1'b1;
    end
  endfunction

  function automatic void predict_split(logic [7:0] ch, logic present, logic is_last);
    logic [LEN_W-1:0] lo, hi;
    logic unterm;
    arg_beat_t b;
    if (present) absorb_char(ch);
    if (is_last) begin
      unterm = in_quotes || nest_depth != 0;
      trimmed_span(lo, hi);
      if (hi > lo || param_done) begin
        queue_param(1'b1, unterm);
      end else begin
        b = '{ch: 8'h00, present: 1'b0, param_end: 1'b0, string_end: 1'b1,
              unterm: unterm, overflow: 1'b0};
        param_beats_due = {param_beats_due, b};
      end
      clear_split();
    end
  endfunction

  function automatic text_t to_text(string s);
    text_t t;
    int i;
    for (i = 0; i < s.len(); i++) t = {t, 8'(s[i])};
    return t;
  endfunction

  function automatic text_t random_args();
    text_t t;
    int n_params, p, k;
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 12)) t = {t, 8'($urandom_range(255))};
      return t;
    end
    n_params = $urandom_range(1, 4);
    for (p = 0; p < n_params; p++) begin
      if (p != 0) t = {t, CH_COMMA};
      if ($urandom_range(11) == 0) begin
        k = $urandom_range(PARAM_LEN + 1, PARAM_LEN + 8);
        repeat (k) t = {t, rand_lower()};
        if ($urandom_range(1)) begin
          t = {t, CH_BSLASH};
          t = {t, $urandom_range(1) ? CH_QUOTE : CH_BSLASH};
        end
      end else begin
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(9))
            0, 1, 2, 9: t = {t, rand_lower()};
            3: repeat ($urandom_range(1, 2)) t = {t, CH_SPACE};
            4: begin
              t = {t, CH_QUOTE};
              repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(3))
                  0: t = {t, CH_COMMA};
                  1: t = {t, CH_SPACE};
                  2: t = {t, CH_OPEN};
                  default: t = {t, rand_lower()};
                endcase
              end
              if ($urandom_range(3) == 0) begin
                t = {t, CH_BSLASH};
                t = {t, $urandom_range(1) ? CH_QUOTE : CH_BSLASH};
              end
              if ($urandom_range(7) != 0) t = {t, CH_QUOTE};
            end
            5: begin
              t = {t, CH_OPEN};
              t = {t, rand_lower()};
              if ($urandom_range(1)) begin
                t = {t, CH_COMMA};
                t = {t, rand_lower()};
              end
              if ($urandom_range(5) != 0) t = {t, CH_CLOSE};
            end
            6: begin
              t = {t, CH_BSLASH};
              case ($urandom_range(2))
                0: t = {t, CH_QUOTE};
                1: t = {t, CH_BSLASH};
                default: t = {t, rand_lower()};
              endcase
            end
            7: t = {t, 8'($urandom_range(255))};
            default: begin
              case ($urandom_range(2))
                0: t = {t, CH_OPEN};
                1: t = {t, CH_CLOSE};
                default: t = {t, CH_QUOTE};
              endcase
            end
          endcase
        end
      end
    end
    return t;
  endfunction

  task automatic send_beat(input logic [7:0] ch, input logic present, input logic is_last);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    s_axis_tuser_i  <= present;
    s_axis_tlast_i  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_split(ch, present, is_last);
    if (present || is_last) items_sent++;
  endtask

  task automatic send_text(input text_t t);
    int i;
    bit marker_end;
    marker_end = (t.size() == 0) || (noise_on && $urandom_range(4) == 0);
    for (i = 0; i < t.size(); i++) begin
      if (noise_on && $urandom_range(15) == 0)
        send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
      send_beat(t[i], 1'b1, !marker_end && (i == t.size() - 1));
    end
    if (marker_end) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
    strings_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (param_beats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_beat(8'hA5, 1'b0, 1'b0);
    send_beat(8'h5A, 1'b0, 1'b1);
    send_text(to_text(","));
    send_text(to_text(" \"a\\\",b\" , (c,d) "));
    send_text(to_text("\"\\\\("));
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(CH_CLOSE, 1'b1, 1'b0);
    send_beat(CH_OPEN, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_overflow();
    text_t t;
    int i;
    for (i = 0; i < PARAM_LEN + 2; i++) t = {t, LOWER_A + 8'(i % 26)};
    t = {t, CH_BSLASH};
    t = {t, CH_QUOTE};
    t = {t, CH_COMMA};
    t = {t, CH_QUOTE};
    for (i = 0; i < PARAM_LEN - 2; i++) t = {t, LOWER_A + 8'(i % 26)};
    t = {t, CH_QUOTE};
    send_text(t);
  endtask

  task automatic test_backpressure();
    int i;
    // hold the output so the block backs up onto its input
    rx_hold_req = HOLD_CYCLES;
    for (i = 0; i < 3; i++) send_text(to_text("ab, cd ,\"e,f\",(g,h),ij"));
    drain_results();
  endtask

  task automatic test_nesting();
    send_text(to_text(") a,((b,c),d),e("));
  endtask

  task automatic test_random(input int n_items);
    int goal;
    goal = items_sent + n_items;
    noise_on = 1'b1;
    while (items_sent < goal) send_text(random_args());
    noise_on = 1'b0;
    drain_results();
  endtask

  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (param_beats_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected beat, expected none, got tdata %0h", $time,
                   m_axis_tdata_o);
        mismatches++;
      end else begin
        head_beat = param_beats_due.pop_front();
        check_field("out_char", head_beat.ch, m_axis_tdata_o[7:0]);
        check_field("char_present", 8'(head_beat.present), 8'(m_axis_tuser_o));
        check_field("param_end", 8'(head_beat.param_end), 8'(m_axis_tlast_o));
        check_field("string_end", 8'(head_beat.string_end), 8'(m_axis_tdata_o[8]));
        check_field("unterminated", 8'(head_beat.unterm), 8'(m_axis_tdata_o[9]));
        check_field("overflowed", 8'(head_beat.overflow), 8'(m_axis_tdata_o[10]));
        beats_checked++;
        if (head_beat.param_end) params_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 30;
    rx_idle_pct = 61;
    test_directed();
    test_overflow();
    test_random(35);
    tx_idle_pct = 61;
    rx_idle_pct = 30;
    test_backpressure();
    test_random(35);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_nesting();
    test_random(35);
    $display("%0d strings, %0d input beats; %0d result beats in %0d parameters checked",
             strings_sent, items_sent, beats_checked, params_checked);
    $display("splits, trimming, quote stripping, escapes, nesting, overflow and stalls run");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
